### hdl/lrupr_pkg.sv
// Package for the LRU page replacement core: default sizes, register map,
// and the control structs shared by the cell chain and the controller.
// No dependencies.
`default_nettype none

package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 4;
    localparam int CNT_W         = 32;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd8;

    // word index of each register (paddr above the byte lanes)
    localparam logic [APB_ADDR_W-3:0] REG_FRAMES_IN_USE = '0;

    // search packet status moving down the chain
    typedef struct packed {
        logic valid;
        logic hit;
        logic found;
    } srch_flags_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic en;
        logic age_all;
        logic wr_page;
    } upd_ctl_t;

endpackage

`default_nettype wire

### hdl/lrupr_if.sv
// Valid/ready channel interfaces of the LRU page replacement core:
// page reference requests and replacement results. Depends on lrupr_pkg.
`default_nettype none

interface lrupr_req_if import lrupr_pkg::*; #(
    parameter int PAGE_BITS = PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if import lrupr_pkg::*; #(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    localparam int SLOT_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1
);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [CNT_W-1:0]     fault_count;
    logic [CNT_W-1:0]     access_count;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_page, output fault_count, output access_count,
                    input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_page, input fault_count, input access_count,
                    output ready);
endinterface

`default_nettype wire

### hdl/lrupr_cell.sv
// One frame cell: holds a resident page, its valid bit and recency rank,
// and passes the search packet one cell further each cycle. Uses lrupr_pkg.
`default_nettype none

module lrupr_cell import lrupr_pkg::*; #(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int IDX       = 0,
    localparam int SLOT_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int LIM_W    = $clog2(FRAMES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [LIM_W-1:0]     limit,
    input  wire srch_flags_t          in_flags,
    input  wire logic [PAGE_BITS-1:0] in_page,
    input  wire logic [SLOT_W-1:0]    in_hit_slot,
    input  wire logic [SLOT_W-1:0]    in_hit_rank,
    input  wire logic [SLOT_W-1:0]    in_vic_slot,
    input  wire logic [SLOT_W-1:0]    in_vic_rank,
    input  wire logic [PAGE_BITS-1:0] in_vic_page,
    output srch_flags_t               out_flags,
    output logic [PAGE_BITS-1:0]      out_page,
    output logic [SLOT_W-1:0]         out_hit_slot,
    output logic [SLOT_W-1:0]         out_hit_rank,
    output logic [SLOT_W-1:0]         out_vic_slot,
    output logic [SLOT_W-1:0]         out_vic_rank,
    output logic [PAGE_BITS-1:0]      out_vic_page,
    input  wire upd_ctl_t             upd,
    input  wire logic [SLOT_W-1:0]    upd_slot,
    input  wire logic [SLOT_W-1:0]    upd_rank,
    input  wire logic [PAGE_BITS-1:0] upd_page
);

    logic                 valid_reg;
    logic [SLOT_W-1:0]    rank_reg;
    logic [PAGE_BITS-1:0] page_reg;

    srch_flags_t          flags_reg, flags_next;
    logic [PAGE_BITS-1:0] pkt_page_reg;
    logic [SLOT_W-1:0]    hit_slot_reg, hit_slot_next;
    logic [SLOT_W-1:0]    hit_rank_reg, hit_rank_next;
    logic [SLOT_W-1:0]    vic_slot_reg, vic_slot_next;
    logic [SLOT_W-1:0]    vic_rank_reg, vic_rank_next;
    logic [PAGE_BITS-1:0] vic_page_reg, vic_page_next;

    logic in_range, match, better, self;

    assign in_range = LIM_W'(IDX) < limit;
    assign match    = in_range && valid_reg && (page_reg == in_page) && !in_flags.hit;
    assign better   = in_range && valid_reg && (!in_flags.found || (rank_reg > in_vic_rank));
    assign self     = upd_slot == SLOT_W'(IDX);

    always_comb
    begin
        flags_next.valid = in_flags.valid;
        flags_next.hit   = in_flags.hit || match;
        flags_next.found = in_flags.found || better;
        hit_slot_next    = match ? SLOT_W'(IDX) : in_hit_slot;
        hit_rank_next    = match ? rank_reg : in_hit_rank;
        vic_slot_next    = better ? SLOT_W'(IDX) : in_vic_slot;
        vic_rank_next    = better ? rank_reg : in_vic_rank;
        vic_page_next    = better ? page_reg : in_vic_page;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (upd.en)
            begin
                if (self)
                begin
                    valid_reg <= 1'b1;
                    rank_reg  <= '0;
                end
                else if (valid_reg && (upd.age_all || (rank_reg < upd_rank)))
                begin
                    rank_reg <= rank_reg + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_page_reg <= in_page;
        hit_slot_reg <= hit_slot_next;
        hit_rank_reg <= hit_rank_next;
        vic_slot_reg <= vic_slot_next;
        vic_rank_reg <= vic_rank_next;
        vic_page_reg <= vic_page_next;
        if (upd.en && self && upd.wr_page)
        begin
            page_reg <= upd_page;
        end
    end

    assign out_flags    = flags_reg;
    assign out_page     = pkt_page_reg;
    assign out_hit_slot = hit_slot_reg;
    assign out_hit_rank = hit_rank_reg;
    assign out_vic_slot = vic_slot_reg;
    assign out_vic_rank = vic_rank_reg;
    assign out_vic_page = vic_page_reg;

endmodule

`default_nettype wire

### hdl/lrupr_ctrl.sv
// Sequencer of the LRU page replacement core: takes a reference, launches
// the search down the cell chain, decides hit/fill/evict, issues the cell
// update and holds the result and the counters. Uses lrupr_pkg, lrupr_if.
`default_nettype none

module lrupr_ctrl import lrupr_pkg::*; #(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    localparam int SLOT_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int LIM_W    = $clog2(FRAMES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    lrupr_req_if.sink                 req,
    lrupr_rsp_if.source               rsp,
    input  wire logic [LIM_W-1:0]     limit,
    output srch_flags_t               inj_flags,
    output logic [PAGE_BITS-1:0]      inj_page,
    input  wire srch_flags_t          fin_flags,
    input  wire logic [SLOT_W-1:0]    fin_hit_slot,
    input  wire logic [SLOT_W-1:0]    fin_hit_rank,
    input  wire logic [SLOT_W-1:0]    fin_vic_slot,
    input  wire logic [SLOT_W-1:0]    fin_vic_rank,
    input  wire logic [PAGE_BITS-1:0] fin_vic_page,
    output upd_ctl_t                  upd,
    output logic [SLOT_W-1:0]         upd_slot,
    output logic [SLOT_W-1:0]         upd_rank,
    output logic [PAGE_BITS-1:0]      upd_page
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE
    } state_t;

    state_t               state_reg;
    srch_flags_t          inj_flags_reg;
    logic [PAGE_BITS-1:0] page_reg;

    logic                 fin_hit_reg;
    logic [SLOT_W-1:0]    fin_hit_slot_reg, fin_hit_rank_reg;
    logic [SLOT_W-1:0]    fin_vic_slot_reg, fin_vic_rank_reg;
    logic [PAGE_BITS-1:0] fin_vic_page_reg;

    logic [LIM_W-1:0]     filled_reg;
    logic [CNT_W-1:0]     faults_reg, refs_reg;

    upd_ctl_t             upd_reg;
    logic [SLOT_W-1:0]    upd_slot_reg, upd_rank_reg;

    logic                 rsp_valid_reg, rsp_hit_reg, rsp_ev_reg;
    logic [SLOT_W-1:0]    rsp_slot_reg;
    logic [PAGE_BITS-1:0] rsp_ev_page_reg;

    upd_ctl_t             dec_upd;
    logic [SLOT_W-1:0]    dec_slot, dec_rank;
    logic                 dec_ev, dec_fill, out_free, dec_go;
    logic [PAGE_BITS-1:0] dec_ev_page;
    logic [CNT_W-1:0]     faults_next, refs_next;

    always_comb
    begin
        dec_upd     = '{en: 1'b1, age_all: 1'b0, wr_page: 1'b0};
        dec_slot    = fin_hit_slot_reg;
        dec_rank    = fin_hit_rank_reg;
        dec_ev      = 1'b0;
        dec_ev_page = '0;
        dec_fill    = 1'b0;
        if (!fin_hit_reg)
        begin
            dec_upd.wr_page = 1'b1;
            if (filled_reg < limit)
            begin
                dec_slot        = filled_reg[SLOT_W-1:0];
                dec_upd.age_all = 1'b1;
                dec_fill        = 1'b1;
            end
            else
            begin
                dec_slot    = fin_vic_slot_reg;
                dec_rank    = fin_vic_rank_reg;
                dec_ev      = 1'b1;
                dec_ev_page = fin_vic_page_reg;
            end
        end
    end

    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign dec_go      = (state_reg == S_DECIDE) && out_free;
    assign refs_next   = (refs_reg == '1) ? refs_reg : refs_reg + CNT_W'(1);
    assign faults_next = (fin_hit_reg || (faults_reg == '1)) ? faults_reg
                                                             : faults_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            inj_flags_reg    <= '0;
            page_reg         <= '0;
            fin_hit_reg      <= 1'b0;
            fin_hit_slot_reg <= '0;
            fin_hit_rank_reg <= '0;
            fin_vic_slot_reg <= '0;
            fin_vic_rank_reg <= '0;
            fin_vic_page_reg <= '0;
            filled_reg       <= '0;
            faults_reg       <= '0;
            refs_reg         <= '0;
            upd_reg          <= '0;
            upd_slot_reg     <= '0;
            upd_rank_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
            rsp_hit_reg      <= 1'b0;
            rsp_ev_reg       <= 1'b0;
            rsp_slot_reg     <= '0;
            rsp_ev_page_reg  <= '0;
        end
        else
        begin
            inj_flags_reg <= '{valid: (state_reg == S_IDLE) && req.valid,
                               hit: 1'b0, found: 1'b0};
            if (dec_go)
            begin
                upd_reg       <= dec_upd;
                rsp_valid_reg <= 1'b1;
            end
            else
            begin
                upd_reg <= '0;
                if (rsp.ready)
                begin
                    rsp_valid_reg <= 1'b0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        page_reg  <= req.page_number;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (fin_flags.valid)
                    begin
                        fin_hit_reg      <= fin_flags.hit;
                        fin_hit_slot_reg <= fin_hit_slot;
                        fin_hit_rank_reg <= fin_hit_rank;
                        fin_vic_slot_reg <= fin_vic_slot;
                        fin_vic_rank_reg <= fin_vic_rank;
                        fin_vic_page_reg <= fin_vic_page;
                        state_reg        <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        upd_slot_reg    <= dec_slot;
                        upd_rank_reg    <= dec_rank;
                        rsp_hit_reg     <= fin_hit_reg;
                        rsp_slot_reg    <= dec_slot;
                        rsp_ev_reg      <= dec_ev;
                        rsp_ev_page_reg <= dec_ev_page;
                        faults_reg      <= faults_next;
                        refs_reg        <= refs_next;
                        if (dec_fill)
                        begin
                            filled_reg <= filled_reg + LIM_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign inj_flags         = inj_flags_reg;
    assign inj_page          = page_reg;
    assign upd               = upd_reg;
    assign upd_slot          = upd_slot_reg;
    assign upd_rank          = upd_rank_reg;
    assign upd_page          = page_reg;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = rsp_hit_reg;
    assign rsp.slot          = rsp_slot_reg;
    assign rsp.evicted_valid = rsp_ev_reg;
    assign rsp.evicted_page  = rsp_ev_page_reg;
    assign rsp.fault_count   = faults_reg;
    assign rsp.access_count  = refs_reg;

    a_fin_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        fin_flags.valid |-> state_reg == S_SEARCH)
        else $error("search packet left the chain outside the search phase");

    a_upd_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        upd_reg.en |-> $past(state_reg) == S_DECIDE && state_reg == S_IDLE)
        else $error("cell update issued without a decision");

    a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_ev_reg |-> !rsp_hit_reg)
        else $error("eviction reported on a hit");

    a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
        faults_reg <= refs_reg)
        else $error("fault count above access count");

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= LIM_W'(FRAMES))
        else $error("filled slot count beyond frame count");

endmodule

`default_nettype wire

### hdl/lru_page_replacement_core.sv
// Top level of the LRU page replacement core: APB register, frame limit,
// the chain of frame cells and the sequencer.
// Depends on lrupr_pkg, lrupr_if, lrupr_cell, lrupr_ctrl.
//
//  port group   dir   handshake            payload
//  req          in    valid/ready          page_number
//  rsp          out   valid/ready          hit, slot, evicted_valid, evicted_page,
//                                          fault_count, access_count
//  apb          in    psel/penable/pready  paddr, pwrite, pwdata -> prdata
//
// The search packet walks the cell chain one cell per cycle; the controller then
// decides and registers the cell update before it takes the next reference.
// A finished result waits in the output register; the next reference is taken
// while it waits, and the decision stalls only if the previous result is still held.
// Reset empties every frame, clears both counters and sets frames_in_use to 8.
`default_nettype none

module lru_page_replacement_core import lrupr_pkg::*; #(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lrupr_req_if.sink                  req,
    lrupr_rsp_if.source                rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LIM_W  = $clog2(FRAMES + 1);
    localparam int CMP_W  = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    logic [CFG_W-1:0] frames_reg;
    logic             reg_sel;
    logic [CMP_W-1:0] cfg_ext, lim_ext;
    logic [LIM_W-1:0] limit;

    assign reg_sel = paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(APB_DATA_W-CFG_W){1'b0}}, frames_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= FRAMES_IN_USE_RST;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            frames_reg <= pwdata[CFG_W-1:0];
        end
    end

    // zero acts as one, anything above FRAMES as FRAMES
    always_comb
    begin
        cfg_ext = CMP_W'(frames_reg);
        if (cfg_ext == '0)
        begin
            lim_ext = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(FRAMES))
        begin
            lim_ext = CMP_W'(FRAMES);
        end
        else
        begin
            lim_ext = cfg_ext;
        end
    end
    assign limit = lim_ext[LIM_W-1:0];

    srch_flags_t          ch_flags    [FRAMES+1];
    logic [PAGE_BITS-1:0] ch_page     [FRAMES+1];
    logic [SLOT_W-1:0]    ch_hit_slot [FRAMES+1];
    logic [SLOT_W-1:0]    ch_hit_rank [FRAMES+1];
    logic [SLOT_W-1:0]    ch_vic_slot [FRAMES+1];
    logic [SLOT_W-1:0]    ch_vic_rank [FRAMES+1];
    logic [PAGE_BITS-1:0] ch_vic_page [FRAMES+1];

    upd_ctl_t             upd;
    logic [SLOT_W-1:0]    upd_slot, upd_rank;
    logic [PAGE_BITS-1:0] upd_page;

    assign ch_hit_slot[0] = '0;
    assign ch_hit_rank[0] = '0;
    assign ch_vic_slot[0] = '0;
    assign ch_vic_rank[0] = '0;
    assign ch_vic_page[0] = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        lrupr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .limit        (limit),
            .in_flags     (ch_flags[i]),
            .in_page      (ch_page[i]),
            .in_hit_slot  (ch_hit_slot[i]),
            .in_hit_rank  (ch_hit_rank[i]),
            .in_vic_slot  (ch_vic_slot[i]),
            .in_vic_rank  (ch_vic_rank[i]),
            .in_vic_page  (ch_vic_page[i]),
            .out_flags    (ch_flags[i+1]),
            .out_page     (ch_page[i+1]),
            .out_hit_slot (ch_hit_slot[i+1]),
            .out_hit_rank (ch_hit_rank[i+1]),
            .out_vic_slot (ch_vic_slot[i+1]),
            .out_vic_rank (ch_vic_rank[i+1]),
            .out_vic_page (ch_vic_page[i+1]),
            .upd          (upd),
            .upd_slot     (upd_slot),
            .upd_rank     (upd_rank),
            .upd_page     (upd_page)
        );
    end

    lrupr_ctrl #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .limit        (limit),
        .inj_flags    (ch_flags[0]),
        .inj_page     (ch_page[0]),
        .fin_flags    (ch_flags[FRAMES]),
        .fin_hit_slot (ch_hit_slot[FRAMES]),
        .fin_hit_rank (ch_hit_rank[FRAMES]),
        .fin_vic_slot (ch_vic_slot[FRAMES]),
        .fin_vic_rank (ch_vic_rank[FRAMES]),
        .fin_vic_page (ch_vic_page[FRAMES]),
        .upd          (upd),
        .upd_slot     (upd_slot),
        .upd_rank     (upd_rank),
        .upd_page     (upd_page)
    );

endmodule

`default_nettype wire
